// ===== sv/rmnb_pkg.sv =====
package rmnb_pkg;

    localparam int NODES       = 1024;
    localparam int LOAD_BITS   = 20;
    localparam int IDX_W       = $clog2(NODES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ALPHA_W     = 16;
    localparam int MOVED_W     = 21;
    localparam int TOTAL_W     = 32;
    localparam int PROD_W      = ALPHA_W + LOAD_BITS;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_FIELD_W = 1 + 3 * IDX_W + MOVED_W + 2 * TOTAL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [ALPHA_W-1:0]   ALPHA_RESET = ALPHA_W'(5464);
    localparam logic [LOAD_BITS-1:0] LOAD_MAX    = {LOAD_BITS{1'b1}};
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = {TOTAL_W{1'b1}};
    localparam logic [MOVED_W-1:0]   MOVED_MAX   = {MOVED_W{1'b1}};
    localparam logic [9:0]           THOUSAND    = 10'd1000;

    typedef enum logic [15:0] {
        ST_CLEAR    = 16'b0000_0000_0000_0001,
        ST_IDLE     = 16'b0000_0000_0000_0010,
        ST_INC_RD   = 16'b0000_0000_0000_0100,
        ST_INC_WR   = 16'b0000_0000_0000_1000,
        ST_SCAN     = 16'b0000_0000_0001_0000,
        ST_CMP      = 16'b0000_0000_0010_0000,
        ST_DECIDE   = 16'b0000_0000_0100_0000,
        ST_NB_L     = 16'b0000_0000_1000_0000,
        ST_NB_R     = 16'b0000_0001_0000_0000,
        ST_NB_Z     = 16'b0000_0010_0000_0000,
        ST_REMOVE   = 16'b0000_0100_0000_0000,
        ST_INSERT   = 16'b0000_1000_0000_0000,
        ST_SPLIT    = 16'b0001_0000_0000_0000,
        ST_SPLIT_LO = 16'b0010_0000_0000_0000,
        ST_MAXS     = 16'b0100_0000_0000_0000,
        ST_OUT      = 16'b1000_0000_0000_0000
    } state_t;

endpackage

// ===== sv/rmnb_ram.sv =====
module rmnb_ram #(
    parameter int WIDTH  = 20,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/ring_min_node_rejoin_balancer_unit.sv =====
// Ring load balancer with min-node rejoin. Each request on the slave stream
// adds one item to the node at target_node, finds the first least-loaded node,
// and, when load[target]*1000 exceeds alpha_milli*load[min], hands the minimum
// node's items to its lighter ring neighbor (right neighbor on a tie), removes
// that entry, and splits the target node in two next to its position. One
// result request follows every input request. All node loads live in a single
// 1024 x 20 synchronous RAM with one write and one read port, and every step
// walks that RAM: a step with no rebalance makes one full min scan and one
// full max scan, and a rebalancing step adds one remove pass from the minimum
// node up and one insert pass from the top down to the target. After reset a
// clearing pass zeroes the RAM before the first request is taken; alpha_milli
// writes are taken at any time, and a finished result waits in an output
// register while the next request is accepted.
module ring_min_node_rejoin_balancer_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rmnb_pkg::ALPHA_W-1:0]       cfg_wdata,   // alpha_milli
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rmnb_pkg::IN_TDATA_W-1:0]    s_tdata,     // target_node
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // rebalanced, vacated_node, receiving_node, moved_items, move_total,
    // insert_total, heaviest_node
    output logic [rmnb_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    import rmnb_pkg::*;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pend_addr_reg, pend_addr_next;
    logic [IDX_W-1:0]       u_reg, u_next;
    logic                   u_ok_reg, u_ok_next;
    logic [LOAD_BITS-1:0]   lu_reg, lu_next;
    logic [IDX_W-1:0]       v_reg, v_next;
    logic [LOAD_BITS-1:0]   lv_reg, lv_next;
    logic [LOAD_BITS-1:0]   best_reg, best_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [PROD_W-1:0]      prod_u_reg, prod_u_next;
    logic [PROD_W-1:0]      prod_v_reg, prod_v_next;
    logic [LOAD_BITS-1:0]   ll_reg, ll_next;
    logic [IDX_W-1:0]       z_reg, z_next;
    logic [LOAD_BITS-1:0]   lo_reg, lo_next;
    logic [MOVED_W-1:0]     moved_reg, moved_next;
    logic                   reb_reg, reb_next;
    logic [TOTAL_W-1:0]     move_cnt_reg, move_cnt_next;
    logic [TOTAL_W-1:0]     ins_cnt_reg, ins_cnt_next;
    logic [ALPHA_W-1:0]     alpha_reg, alpha_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [LOAD_BITS-1:0]   ram_wdata;
    logic [IDX_W-1:0]       ram_raddr;
    logic [LOAD_BITS-1:0]   ram_rdata;

    logic [IDX_W-1:0]       scan_idx;
    logic [IDX_W-1:0]       left_idx;
    logic [IDX_W-1:0]       right_idx;
    logic [IDX_W-1:0]       up_pos;
    logic [LOAD_BITS:0]     sum_wide;
    logic [LOAD_BITS:0]     hi_wide;
    logic [TOTAL_W:0]       total_wide;
    logic                   take_left;
    logic [LOAD_BITS-1:0]   z_load;

    rmnb_ram #(
        .WIDTH (LOAD_BITS),
        .DEPTH (NODES)
    ) u_loads (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Neighbors of the minimum node around the ring, and the target's slot
    // once the minimum entry has been pulled out below it.
    assign left_idx  = (v_reg == '0) ? IDX_W'(NODES - 1) : v_reg - 1'b1;
    assign right_idx = ({1'b0, v_reg} + 1'b1 >= CNT_W'(NODES)) ? '0 : v_reg + 1'b1;
    assign up_pos    = (v_reg < u_reg) ? u_reg - 1'b1 : u_reg;
    assign scan_idx  = cnt_reg[IDX_W-1:0] - 1'b1;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        u_next         = u_reg;
        u_ok_next      = u_ok_reg;
        lu_next        = lu_reg;
        v_next         = v_reg;
        lv_next        = lv_reg;
        best_next      = best_reg;
        best_idx_next  = best_idx_reg;
        prod_u_next    = prod_u_reg;
        prod_v_next    = prod_v_reg;
        ll_next        = ll_reg;
        z_next         = z_reg;
        lo_next        = lo_reg;
        moved_next     = moved_reg;
        reb_next       = reb_reg;
        move_cnt_next  = move_cnt_reg;
        ins_cnt_next   = ins_cnt_reg;
        alpha_next     = cfg_we ? cfg_wdata : alpha_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        out_data_next  = out_data_reg;

        // Copy passes: data read last cycle lands one slot over.
        ram_we    = pend_reg;
        ram_waddr = pend_addr_reg;
        ram_wdata = ram_rdata;
        ram_raddr = cnt_reg[IDX_W-1:0];

        sum_wide   = '0;
        hi_wide    = '0;
        total_wide = '0;
        take_left  = 1'b0;
        z_load     = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[IDX_W-1:0];
                ram_wdata = '0;
                if (cnt_reg == CNT_W'(NODES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    u_next     = s_tdata[IDX_W-1:0];
                    u_ok_next  = ({1'b0, s_tdata[IDX_W-1:0]} < CNT_W'(NODES));
                    state_next = ST_INC_RD;
                end
            end

            ST_INC_RD:
            begin
                ram_raddr  = u_reg;
                state_next = ST_INC_WR;
            end

            ST_INC_WR:
            begin
                // Add the new item with saturation and count it.
                lu_next = (ram_rdata == LOAD_MAX) ? LOAD_MAX : ram_rdata + 1'b1;
                if (u_ok_reg)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = u_reg;
                    ram_wdata    = lu_next;
                    ins_cnt_next = (ins_cnt_reg == TOTAL_MAX) ? TOTAL_MAX
                                                              : ins_cnt_reg + 1'b1;
                end
                cnt_next   = '0;
                state_next = ST_SCAN;
            end

            ST_SCAN:
            begin
                // First minimum: strict less keeps the lowest index.
                if (cnt_reg != '0)
                begin
                    if (cnt_reg == CNT_W'(1) || ram_rdata < best_reg)
                    begin
                        best_next     = ram_rdata;
                        best_idx_next = scan_idx;
                    end
                end
                if (cnt_reg == CNT_W'(NODES))
                begin
                    state_next = ST_CMP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_CMP:
            begin
                v_next      = best_idx_reg;
                lv_next     = best_reg;
                prod_u_next = PROD_W'(lu_reg) * PROD_W'(THOUSAND);
                prod_v_next = PROD_W'(alpha_reg) * PROD_W'(best_reg);
                state_next  = ST_DECIDE;
            end

            ST_DECIDE:
            begin
                if (u_ok_reg && u_reg != v_reg && prod_u_reg > prod_v_reg)
                begin
                    state_next = ST_NB_L;
                end
                else
                begin
                    reb_next   = 1'b0;
                    moved_next = '0;
                    z_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_MAXS;
                end
            end

            ST_NB_L:
            begin
                ram_raddr  = left_idx;
                state_next = ST_NB_R;
            end

            ST_NB_R:
            begin
                ram_raddr  = right_idx;
                ll_next    = ram_rdata;
                state_next = ST_NB_Z;
            end

            ST_NB_Z:
            begin
                // Lighter neighbor absorbs the vacated items; tie goes right.
                take_left = (ll_reg < ram_rdata);
                z_next    = take_left ? left_idx : right_idx;
                z_load    = take_left ? ll_reg : ram_rdata;
                sum_wide  = {1'b0, z_load} + {1'b0, lv_reg};
                ram_we    = 1'b1;
                ram_waddr = z_next;
                ram_wdata = sum_wide[LOAD_BITS] ? LOAD_MAX : sum_wide[LOAD_BITS-1:0];
                cnt_next  = {1'b0, v_reg} + 1'b1;
                state_next = ST_REMOVE;
            end

            ST_REMOVE:
            begin
                // Shift entries above the vacated node down by one.
                if (cnt_reg < CNT_W'(NODES))
                begin
                    ram_raddr      = cnt_reg[IDX_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_reg[IDX_W-1:0] - 1'b1;
                    cnt_next       = cnt_reg + 1'b1;
                end
                else if (!pend_reg)
                begin
                    cnt_next   = CNT_W'(NODES - 2);
                    state_next = ST_INSERT;
                end
            end

            ST_INSERT:
            begin
                // Shift entries from the top down to open a slot after up_pos.
                ram_raddr = cnt_reg[IDX_W-1:0];
                if (cnt_reg[IDX_W-1:0] == up_pos)
                begin
                    state_next = ST_SPLIT;
                end
                else
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_reg[IDX_W-1:0] + 1'b1;
                    cnt_next       = cnt_reg - 1'b1;
                end
            end

            ST_SPLIT:
            begin
                hi_wide    = ({1'b0, ram_rdata} + 1'b1) >> 1;
                lo_next    = ram_rdata >> 1;
                ram_we     = 1'b1;
                ram_waddr  = up_pos + 1'b1;
                ram_wdata  = hi_wide[LOAD_BITS-1:0];
                moved_next = MOVED_W'(lv_reg) + MOVED_W'(hi_wide);
                reb_next   = 1'b1;
                state_next = ST_SPLIT_LO;
            end

            ST_SPLIT_LO:
            begin
                ram_we        = 1'b1;
                ram_waddr     = up_pos;
                ram_wdata     = lo_reg;
                total_wide    = {1'b0, move_cnt_reg} + (TOTAL_W + 1)'(moved_reg);
                move_cnt_next = total_wide[TOTAL_W] ? TOTAL_MAX : total_wide[TOTAL_W-1:0];
                cnt_next      = '0;
                state_next    = ST_MAXS;
            end

            ST_MAXS:
            begin
                if (cnt_reg != '0)
                begin
                    if (cnt_reg == CNT_W'(1) || ram_rdata > best_reg)
                    begin
                        best_next     = ram_rdata;
                        best_idx_next = scan_idx;
                    end
                end
                if (cnt_reg == CNT_W'(NODES))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_OUT:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_TDATA_W'({best_idx_reg, ins_cnt_reg, move_cnt_reg,
                                                   moved_reg, z_reg, v_reg, reb_reg});
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            move_cnt_reg  <= '0;
            ins_cnt_reg   <= '0;
            alpha_reg     <= ALPHA_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            move_cnt_reg  <= move_cnt_next;
            ins_cnt_reg   <= ins_cnt_next;
            alpha_reg     <= alpha_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        u_reg         <= u_next;
        u_ok_reg      <= u_ok_next;
        lu_reg        <= lu_next;
        v_reg         <= v_next;
        lv_reg        <= lv_next;
        best_reg      <= best_next;
        best_idx_reg  <= best_idx_next;
        prod_u_reg    <= prod_u_next;
        prod_v_reg    <= prod_v_next;
        ll_reg        <= ll_next;
        z_reg         <= z_next;
        lo_reg        <= lo_next;
        moved_reg     <= moved_next;
        reb_reg       <= reb_next;
        out_data_reg  <= out_data_next;
    end

endmodule
